>>> sv/udp_dpfc_pkg.sv
// ----------------------------------------------------------------------------
// udp_dpfc_pkg
// Shared types and header constants for the UDP destination-port frame
// counter: beat structs, the verdict passed to the result stage, offsets.
// ----------------------------------------------------------------------------
package udp_dpfc_pkg;

  // input beat: one frame byte and its last-byte flag
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } in_beat_t;

  // result beat: match flag and running match count
  typedef struct packed {
    logic        frame_matched;
    logic [31:0] match_total;
  } out_beat_t;

  // frame decision handed from the parser to the result stage
  typedef struct packed {
    logic load;
    logic hit;
  } verdict_t;

  // header layout
  localparam int unsigned EthTypeHiPos   = 12;
  localparam int unsigned EthTypeLoPos   = 13;
  localparam int unsigned VerIhlPos      = 14;
  localparam int unsigned ProtoPos       = 23;
  localparam int unsigned EthHdrBytes    = 14;
  localparam int unsigned UdpPortOfs     = 2;
  localparam int unsigned UdpHdrBytes    = 8;
  localparam int unsigned MinFrameBytes  = 34;

  // field values
  localparam logic [15:0] EthertypeIpv4   = 16'h0800;
  localparam logic [3:0]  IpVersion4      = 4'd4;
  localparam logic [7:0]  ProtoUdp        = 8'd17;
  localparam logic [15:0] TargetPortReset = 16'd1234;

endpackage

>>> sv/udp_dest_port_frame_counter.sv
// ----------------------------------------------------------------------------
// udp_dest_port_frame_counter
// Counts Ethernet frames carrying IPv4 UDP to a configured destination port.
// ----------------------------------------------------------------------------
// One byte per cycle unless stalled; the input register feeds the parser directly.
// A frame's result is registered when its last byte leaves the input register.
// in_ready_o drops only while a finished result waits and the held byte ends a frame.
// Reset: clears frame state, the match count and valid flags; target port is 1234.
module udp_dest_port_frame_counter
  import udp_dpfc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_beat_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_beat_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0] target_port_q;
  logic        out_free;
  logic        fwd;
  in_beat_t    beat;
  verdict_t    verdict;

  // target port register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_port_q <= TargetPortReset;
    end else if (cfg_we_i) begin
      target_port_q <= cfg_wdata_i;
    end
  end

  udp_dpfc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_free_i (out_free),
    .fwd_o      (fwd),
    .beat_o     (beat)
  );

  udp_dpfc_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fwd_i         (fwd),
    .beat_i        (beat),
    .target_port_i (target_port_q),
    .verdict_o     (verdict)
  );

  udp_dpfc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .verdict_i   (verdict),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // a frame decision never overwrites a result that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    verdict.load |-> (!out_valid_o || out_ready_i))
    else $error("frame result overwrote a waiting beat");

  // the count advances by the match flag of each new result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    verdict.load |=> (out_data_o.match_total ==
                      $past(out_data_o.match_total) + 32'(out_data_o.frame_matched)))
    else $error("match count did not follow the frame decision");

  // the count holds between frame decisions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !verdict.load |=> $stable(out_data_o.match_total))
    else $error("match count changed without a frame end");

  // back-pressure only from a held end-of-frame beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (beat.end_of_frame && !out_free))
    else $error("input stalled without a pending frame end");

endmodule

>>> sv/udp_dpfc_in_stage.sv
// ----------------------------------------------------------------------------
// udp_dpfc_in_stage
// Input register for frame bytes. A held beat moves on every cycle unless
// it closes a frame while the result register is occupied and not being read.
// ----------------------------------------------------------------------------
module udp_dpfc_in_stage
  import udp_dpfc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_beat_t in_data_i,
  input  logic     out_free_i,
  output logic     fwd_o,
  output in_beat_t beat_o
);

  logic     valid_q;
  in_beat_t beat_q;

  // held beat may move when it does not need the result register, or it is free
  assign fwd_o      = valid_q && (!beat_q.end_of_frame || out_free_i);
  assign in_ready_o = !valid_q || fwd_o;
  assign beat_o     = beat_q;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      beat_q <= in_data_i;
    end
  end

endmodule

>>> sv/udp_dpfc_parser.sv
// ----------------------------------------------------------------------------
// udp_dpfc_parser
// Tracks the byte position, captures the header fields of the frame in
// flight and decides on the last byte whether the frame is counted.
// ----------------------------------------------------------------------------
module udp_dpfc_parser
  import udp_dpfc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fwd_i,
  input  in_beat_t    beat_i,
  input  logic [15:0] target_port_i,
  output verdict_t    verdict_o
);

  localparam int unsigned PosW = $clog2(MAX_FRAME_BYTES + 1);

  logic [PosW-1:0] pos_q, pos_d, pos_n;
  logic [15:0]     eth_type_q, eth_type_d, eth_type_n;
  logic [7:0]      ver_ihl_q, ver_ihl_d, ver_ihl_n;
  logic [7:0]      proto_q, proto_d, proto_n;
  logic [15:0]     port_q, port_d, port_n;
  logic [6:0]      port_at;
  logic [6:0]      need_len;
  logic            room;
  logic            hit;

  // port offset from the ihl held before this byte
  assign port_at = 7'(EthHdrBytes + UdpPortOfs) + {1'b0, ver_ihl_q[3:0], 2'b00};
  assign room    = pos_q < PosW'(MAX_FRAME_BYTES);

  // field capture for the current byte
  always_comb begin
    pos_n      = pos_q;
    eth_type_n = eth_type_q;
    ver_ihl_n  = ver_ihl_q;
    proto_n    = proto_q;
    port_n     = port_q;
    if (room) begin
      if (pos_q == PosW'(EthTypeHiPos)) eth_type_n[15:8] = beat_i.frame_byte;
      if (pos_q == PosW'(EthTypeLoPos)) eth_type_n[7:0]  = beat_i.frame_byte;
      if (pos_q == PosW'(VerIhlPos))    ver_ihl_n        = beat_i.frame_byte;
      if (pos_q == PosW'(ProtoPos))     proto_n          = beat_i.frame_byte;
      if (pos_q == PosW'(port_at))      port_n[15:8]     = beat_i.frame_byte;
      if (pos_q == PosW'(port_at) + PosW'(1)) port_n[7:0] = beat_i.frame_byte;
      pos_n = pos_q + PosW'(1);
    end
  end

  // frame decision on the updated fields
  assign need_len = 7'(EthHdrBytes + UdpHdrBytes) + {1'b0, ver_ihl_n[3:0], 2'b00};
  assign hit = (pos_n >= PosW'(MinFrameBytes))
            && (eth_type_n == EthertypeIpv4)
            && (ver_ihl_n[7:4] == IpVersion4)
            && (proto_n == ProtoUdp)
            && (pos_n >= PosW'(need_len))
            && (port_n == target_port_i);

  assign verdict_o.load = fwd_i && beat_i.end_of_frame;
  assign verdict_o.hit  = hit;

  // next state: clear at frame end
  always_comb begin
    pos_d      = pos_q;
    eth_type_d = eth_type_q;
    ver_ihl_d  = ver_ihl_q;
    proto_d    = proto_q;
    port_d     = port_q;
    if (fwd_i) begin
      if (beat_i.end_of_frame) begin
        pos_d      = '0;
        eth_type_d = '0;
        ver_ihl_d  = '0;
        proto_d    = '0;
        port_d     = '0;
      end else begin
        pos_d      = pos_n;
        eth_type_d = eth_type_n;
        ver_ihl_d  = ver_ihl_n;
        proto_d    = proto_n;
        port_d     = port_n;
      end
    end
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      eth_type_q <= '0;
      ver_ihl_q  <= '0;
      proto_q    <= '0;
      port_q     <= '0;
    end else begin
      pos_q      <= pos_d;
      eth_type_q <= eth_type_d;
      ver_ihl_q  <= ver_ihl_d;
      proto_q    <= proto_d;
      port_q     <= port_d;
    end
  end

endmodule

>>> sv/udp_dpfc_out_stage.sv
// ----------------------------------------------------------------------------
// udp_dpfc_out_stage
// Result register and match counter. The counter register is the
// match_total field of the result beat.
// ----------------------------------------------------------------------------
module udp_dpfc_out_stage
  import udp_dpfc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  verdict_t  verdict_i,
  output logic      out_free_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  logic        valid_q, valid_d;
  logic        matched_q;
  logic [31:0] count_q, count_d;

  assign out_free_o = !valid_q || out_ready_i;

  // valid and counter update
  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    if (out_ready_i) valid_d = 1'b0;
    if (verdict_i.load) begin
      valid_d = 1'b1;
      count_d = count_q + 32'(verdict_i.hit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      count_q <= '0;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  // match flag
  always_ff @(posedge clk_i) begin
    if (verdict_i.load) begin
      matched_q <= verdict_i.hit;
    end
  end

  assign out_valid_o              = valid_q;
  assign out_data_o.frame_matched = matched_q;
  assign out_data_o.match_total   = count_q;

endmodule
